FILE: sv/lwma3_pkg.sv
// ----------------------------------------------------------------------------
// lwma3_pkg
// shared types and constants for the difficulty retarget core
// ----------------------------------------------------------------------------
package lwma3_pkg;
  localparam int MAX_WINDOW = 1024;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);

  // ceil(2^66 / 25); with a two-bit pre-shift gives floor(x / 100) from bits 123:66
  localparam logic [61:0] RECIP_100 = 62'h28F5C28F5C28F5C3;

  localparam logic [2:0] REG_SPACING    = 3'd0;
  localparam logic [2:0] REG_WINDOW     = 3'd1;
  localparam logic [2:0] REG_MIN_EARLY  = 3'd2;
  localparam logic [2:0] REG_MIN_NORMAL = 3'd3;
  localparam logic [2:0] REG_TESTNET    = 3'd4;

  typedef struct packed {
    logic accum;
    logic fin_start;
    logic mul_step;
    logic div_start;
    logic finish;
  } lwma3_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic short_hist;
  } lwma3_status_t;
endpackage

FILE: sv/lwma3_datapath.sv
// ----------------------------------------------------------------------------
// lwma3_datapath
// accumulation registers, multiply sequence, serial divider and clamps
// ----------------------------------------------------------------------------
module lwma3_datapath
  import lwma3_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  lwma3_cmd_t        cmd,
  output lwma3_status_t     status,
  input  logic [16:0]       spacing_reg,
  input  logic [10:0]       window_reg,
  input  logic [63:0]       min_early,
  input  logic [63:0]       min_normal,
  input  logic              testnet,
  input  logic [63:0]       timestamp,
  input  logic [63:0]       work_low,
  input  logic [63:0]       work_high,
  input  logic [7:0]        block_version,
  output logic [63:0]       difficulty
);
  logic [CNT_W-1:0] item_count;
  logic [63:0] previous_time, wsum;
  logic [63:0] rs0, rs1, rs2;
  logic [63:0] fw0, fw1, bw0, bw1, lw0, lw1;
  logic [7:0]  version;
  logic [63:0] prod, den, quo, rem;
  logic [6:0]  div_cnt;
  logic [2:0]  mstep;
  logic        div_busy;
  logic [63:0] nd, pd, floor_d, sum3;
  logic        bad;
  logic        fast_ok;

  logic [16:0] t_eff;
  logic [CNT_W-1:0] win_eff;
  logic [63:0] this_time, span, cap;
  logic [64:0] rem_sh;
  logic [63:0] nd_hi, pd_hi;

  // bounds by reciprocal multiply, one 32x32 partial product a cycle
  logic         bnd_busy;
  logic [1:0]   bnd_sel, bnd_pp;
  logic [63:0]  bnd_y;
  logic [31:0]  pp_a, pp_m;
  logic [63:0]  pp_p;
  logic [123:0] pp_term, bnd_acc, bnd_acc_next;

  assign t_eff = (spacing_reg == 17'd0) ? 17'd1 : spacing_reg;
  always_comb begin
    if (window_reg < 11'd12) win_eff = CNT_W'(12);
    else if (32'(window_reg) > MAX_WINDOW) win_eff = CNT_W'(MAX_WINDOW);
    else win_eff = CNT_W'(window_reg);
    cap = 64'(t_eff) * 64'd6;
    this_time = (timestamp > previous_time) ? timestamp : previous_time + 64'd1;
    span = this_time - previous_time;
    if (span > cap) span = cap;
    {nd_hi, nd} = {lw1, lw0} - {fw1, fw0};
    {pd_hi, pd} = {lw1, lw0} - {bw1, bw0};
    rem_sh = {rem, quo[63]};
    sum3 = rs0 + rs1 + rs2;
  end

  always_comb begin
    case (bnd_sel)
      2'd0:    bnd_y = pd * 64'd67;
      2'd1:    bnd_y = pd * 64'd150;
      default: bnd_y = pd * 64'd108;
    endcase
    pp_a = bnd_pp[1] ? {2'b00, bnd_y[63:34]} : bnd_y[33:2];
    pp_m = bnd_pp[0] ? {2'b00, RECIP_100[61:32]} : RECIP_100[31:0];
    pp_p = 64'(pp_a) * 64'(pp_m);
    case (bnd_pp)
      2'd0:    pp_term = {60'd0, pp_p};
      2'd3:    pp_term = {pp_p[59:0], 64'd0};
      default: pp_term = {28'd0, pp_p, 32'd0};
    endcase
    bnd_acc_next = bnd_acc + pp_term;
  end

  assign status.div_busy = div_busy || bnd_busy;
  assign status.short_hist = (32'(item_count) <= 10);

  logic [63:0] lo_b, hi_b, fast_b, res;
  always_comb begin
    res = quo;
    if (res > hi_b) res = hi_b;
    if (res < lo_b) res = lo_b;
    if (fast_ok && res < fast_b) res = fast_b;
    if (res < floor_d) res = floor_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0; previous_time <= '0; wsum <= '0;
      rs0 <= '0; rs1 <= '0; rs2 <= '0; div_busy <= 1'b0;
      bnd_busy <= 1'b0;
    end else begin
      if (cmd.accum) begin
        version <= block_version;
        if (item_count == '0) begin
          previous_time <= timestamp;
          fw0 <= work_low; fw1 <= work_high;
          lw0 <= work_low; lw1 <= work_high;
          item_count <= CNT_W'(1);
        end else if (item_count < win_eff) begin
          previous_time <= this_time;
          wsum <= wsum + span * 64'(item_count);
          rs0 <= rs1; rs1 <= rs2; rs2 <= span;
          bw0 <= lw0; bw1 <= lw1;
          lw0 <= work_low; lw1 <= work_high;
          item_count <= item_count + CNT_W'(1);
        end
      end
      if (cmd.fin_start) begin
        floor_d <= (version == 8'd1 || testnet) ? min_early : min_normal;
        bad <= (nd_hi != 64'd0) || (pd_hi != 64'd0);
        // sum3 < floor(8t / 10) as an exact compare
        fast_ok <= (sum3 * 64'd10 + 64'd10) <= (64'(t_eff) * 64'd8);
        prod <= nd;
        den <= wsum * 64'd200;
        mstep <= 3'd0;
      end
      if (cmd.mul_step) begin
        case (mstep)
          3'd0: prod <= prod * 64'(t_eff);
          3'd1: prod <= prod * 64'(item_count);
          default: prod <= prod * 64'd99;
        endcase
        mstep <= mstep + 3'd1;
      end
      if (cmd.div_start) begin
        quo <= prod; rem <= '0; div_cnt <= 7'd0; div_busy <= 1'b1;
      end else if (div_busy) begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= 64'(rem_sh - {1'b0, den}); quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh[63:0]; quo <= {quo[62:0], 1'b0};
        end
        div_cnt <= div_cnt + 7'd1;
        if (div_cnt == 7'd63) div_busy <= 1'b0;
      end
      if (cmd.div_start) begin
        bnd_busy <= 1'b1; bnd_sel <= 2'd0; bnd_pp <= 2'd0; bnd_acc <= '0;
      end else if (bnd_busy) begin
        bnd_pp <= bnd_pp + 2'd1;
        if (bnd_pp == 2'd3) begin
          bnd_acc <= '0;
          case (bnd_sel)
            2'd0:    lo_b <= {6'd0, bnd_acc_next[123:66]};
            2'd1:    hi_b <= {6'd0, bnd_acc_next[123:66]};
            default: fast_b <= {6'd0, bnd_acc_next[123:66]};
          endcase
          bnd_sel <= bnd_sel + 2'd1;
          if (bnd_sel == 2'd2) bnd_busy <= 1'b0;
        end else begin
          bnd_acc <= bnd_acc_next;
        end
      end
      if (cmd.finish) begin
        if (32'(item_count) <= 10) difficulty <= floor_d;
        else if (bad) difficulty <= 64'd0;
        else difficulty <= res;
        item_count <= '0; previous_time <= '0; wsum <= '0;
        rs0 <= '0; rs1 <= '0; rs2 <= '0;
      end
    end
  end
endmodule

FILE: sv/lwma3_ctrl.sv
// ----------------------------------------------------------------------------
// lwma3_ctrl
// sequencer for accumulation, final multiply, divide and result handshake
// ----------------------------------------------------------------------------
module lwma3_ctrl
  import lwma3_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          final_item,
  output logic          out_valid,
  input  logic          out_stall,
  output lwma3_cmd_t    cmd,
  input  lwma3_status_t status
);
  typedef enum logic [2:0] {S_IDLE, S_PREP, S_MUL, S_DIVGO, S_DIV, S_DONE} state_t;
  state_t state;
  logic [1:0] mcnt;
  logic acc;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign acc = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    cmd.accum = acc;
    cmd.fin_start = (state == S_PREP);
    cmd.mul_step = (state == S_MUL);
    cmd.div_start = (state == S_DIVGO);
    cmd.finish = (state == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; mcnt <= '0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (acc && final_item) state <= S_PREP;
        S_PREP: begin
          mcnt <= '0;
          state <= status.short_hist ? S_DONE : S_MUL;
        end
        S_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) state <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIV;
        S_DIV: if (!status.div_busy) state <= S_DONE;
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: sv/difficulty_retarget_lwma3_core.sv
// ----------------------------------------------------------------------------
// difficulty_retarget_lwma3_core
// weighted moving average difficulty retarget over a block history
// ----------------------------------------------------------------------------
// channel  direction  signals
// input    in         in_valid/in_stall, timestamp, work_*, block_version, final_item
// output   out        out_valid/out_stall, difficulty
// config   in         cfg_we, cfg_index, cfg_data
// history items are accepted back to back unless the input stalls; a final item's
// result follows three multiply steps then a 64-step shift-subtract divider,
// with the clamp bounds computed alongside; a short history skips the multiply and divide
// reset is synchronous and clears history and registers to defaults
// input stalls during the final computation and while a result waits
// ----------------------------------------------------------------------------
module difficulty_retarget_lwma3_core
  import lwma3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] timestamp,
  input  logic [63:0] work_low,
  input  logic [63:0] work_high,
  input  logic [7:0]  block_version,
  input  logic        final_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] difficulty,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  logic [16:0] spacing_reg;
  logic [10:0] window_reg;
  logic [63:0] min_early, min_normal;
  logic        testnet;
  lwma3_cmd_t    cmd;
  lwma3_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing_reg <= 17'd120; window_reg <= 11'd60;
      min_early <= 64'd1; min_normal <= 64'd100000; testnet <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPACING:    spacing_reg <= cfg_data[16:0];
        REG_WINDOW:     window_reg <= cfg_data[10:0];
        REG_MIN_EARLY:  min_early <= cfg_data;
        REG_MIN_NORMAL: min_normal <= cfg_data;
        REG_TESTNET:    testnet <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lwma3_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .final_item,
    .out_valid, .out_stall, .cmd, .status
  );

  lwma3_datapath u_dp (
    .clk, .rst, .cmd, .status, .spacing_reg, .window_reg, .min_early,
    .min_normal, .testnet, .timestamp, .work_low, .work_high,
    .block_version, .difficulty
  );
endmodule

FILE: dv/difficulty_retarget_lwma3_core_test.sv
// ----------------------------------------------------------------------------
// difficulty_retarget_lwma3_core_test
// sends block histories through the retarget core and compares every
// difficulty result against an in-bench predictor, under several idle and
// stall mixes and a range of register settings
// ----------------------------------------------------------------------------
module difficulty_retarget_lwma3_core_test;
  import lwma3_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] timestamp = '0;
  logic [63:0] work_low = '0;
  logic [63:0] work_high = '0;
  logic [7:0]  block_version = '0;
  logic        final_item = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] difficulty;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_SPACING;
  logic [63:0] cfg_data = '0;

  difficulty_retarget_lwma3_core u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor registers and history
  logic [16:0]  spacing_reg;
  logic [10:0]  window_reg;
  logic [63:0]  floor_early_reg;
  logic [63:0]  floor_normal_reg;
  logic         testnet_reg;
  int           hist_count;
  logic [63:0]  hist_prev_time;
  logic [63:0]  hist_weighted_sum;
  logic [63:0]  hist_spans [3];
  logic [127:0] hist_first_work;
  logic [127:0] hist_before_last_work;
  logic [127:0] hist_last_work;

  logic [63:0]  difficulty_q [$];
  int           errors;
  int           items_sent;
  int           results_seen;
  int           cycles;
  int unsigned  send_idle_pct;
  int unsigned  stall_pct;
  int           hold_req;
  int           hold_left;

  // running chain for well-formed histories
  logic [63:0]  chain_time;
  logic [127:0] chain_work;

  function automatic void clear_history();
    hist_count = 0;
    hist_prev_time = '0;
    hist_weighted_sum = '0;
    hist_spans = '{default: '0};
    hist_first_work = '0;
    hist_before_last_work = '0;
    hist_last_work = '0;
  endfunction

  function automatic logic [63:0] spacing_eff();
    return (spacing_reg == 0) ? 64'd1 : {47'd0, spacing_reg};
  endfunction

  function automatic int window_eff();
    if (window_reg < 12) return 12;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return int'(window_reg);
  endfunction

  function automatic logic [63:0] retarget(logic [7:0] ver);
    logic [63:0]  floor_d, t, n, num, den, d, pd_lo, lo_b, hi_b, sum3, fast;
    logic [127:0] nd, pd;
    floor_d = (ver == 8'd1 || testnet_reg) ? floor_early_reg : floor_normal_reg;
    t = spacing_eff();
    if (hist_count <= 10) return floor_d;
    n = 64'(hist_count - 1);
    nd = hist_last_work - hist_first_work;
    pd = hist_last_work - hist_before_last_work;
    if (nd[127:64] != 0 || pd[127:64] != 0) return 64'd0;
    pd_lo = pd[63:0];
    num = nd[63:0] * t;
    num = num * (n + 64'd1);
    num = num * 64'd99;
    den = 64'd200 * hist_weighted_sum;
    d = num / den;
    lo_b = (pd_lo * 64'd67) / 64'd100;
    hi_b = (pd_lo * 64'd150) / 64'd100;
    if (d > hi_b) d = hi_b;
    if (d < lo_b) d = lo_b;
    sum3 = hist_spans[0] + hist_spans[1] + hist_spans[2];
    if (sum3 < (64'd8 * t) / 64'd10) begin
      fast = (pd_lo * 64'd108) / 64'd100;
      if (d < fast) d = fast;
    end
    if (d < floor_d) d = floor_d;
    return d;
  endfunction

  function automatic void absorb_item(logic [63:0] ts, logic [127:0] work,
                                      logic [7:0] ver, logic fin);
    logic [63:0] cap, this_time, span;
    if (hist_count == 0) begin
      hist_prev_time = ts;
      hist_first_work = work;
      hist_last_work = work;
      hist_count = 1;
    end else if (hist_count < window_eff()) begin
      cap = 64'd6 * spacing_eff();
      this_time = (ts > hist_prev_time) ? ts : hist_prev_time + 64'd1;
      span = this_time - hist_prev_time;
      if (span > cap) span = cap;
      hist_prev_time = this_time;
      hist_weighted_sum = hist_weighted_sum + span * 64'(hist_count);
      hist_spans[0] = hist_spans[1];
      hist_spans[1] = hist_spans[2];
      hist_spans[2] = span;
      hist_before_last_work = hist_last_work;
      hist_last_work = work;
      hist_count++;
    end
    if (fin) begin
      difficulty_q = {difficulty_q, retarget(ver)};
      clear_history();
    end
  endfunction

  task automatic send_item(logic [63:0] ts, logic [127:0] work, logic [7:0] ver,
                           logic fin);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    timestamp <= ts;
    work_low <= work[63:0];
    work_high <= work[127:64];
    block_version <= ver;
    final_item <= fin;
    do @(posedge clk); while (in_stall);
    absorb_item(ts, work, ver, fin);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (difficulty_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPACING:    spacing_reg = data[16:0];
      REG_WINDOW:     window_reg = data[10:0];
      REG_MIN_EARLY:  floor_early_reg = data;
      REG_MIN_NORMAL: floor_normal_reg = data;
      REG_TESTNET:    testnet_reg = data[0];
      default: ;
    endcase
  endtask

  // one history of m items; noisy histories use fully random fields
  task automatic send_history(int m, bit noisy, logic [7:0] ver);
    logic [63:0] step;
    for (int i = 0; i < m; i++) begin
      if (noisy) begin
        send_item({$urandom, $urandom},
                  {$urandom, $urandom, $urandom, $urandom},
                  8'($urandom), i == m - 1);
      end else begin
        step = 64'($urandom_range(99, 0) < 10 ? 0 : $urandom % (8 * spacing_eff() + 2));
        chain_time = chain_time + step;
        chain_work = chain_work + ($urandom_range(9, 0) == 0 ?
                     128'({$urandom, $urandom}) : 128'($urandom_range(1 << 30, 1)));
        send_item(chain_time, chain_work, (i == m - 1) ? ver : 8'($urandom),
                  i == m - 1);
      end
    end
  endtask

  task automatic new_chain();
    chain_time = {$urandom_range(3, 0) == 0 ? $urandom : 32'd0, $urandom};
    chain_work = {32'd0, $urandom_range(1, 0) ? $urandom : 32'd0, $urandom, $urandom};
  endtask

  task automatic test_short_histories();
    new_chain();
    send_history(1, 0, 8'd2);
    send_history(10, 0, 8'd1);
    send_history(11, 0, 8'd3);
  endtask

  task automatic test_field_extremes();
    // timestamps near the top wrap, reversed and maximal work
    send_item('1, '1, 8'd255, 1'b0);
    for (int i = 0; i < 11; i++)
      send_item(i[0] ? '1 : 64'd0, 128'(i) << 100, 8'd0, i == 10);
    for (int i = 0; i < 12; i++)
      send_item(64'(i) * 64'd100, '1 - 128'(i), 8'd0, i == 11);
  endtask

  task automatic test_window_limits();
    write_reg(REG_WINDOW, 64'd0);
    new_chain();
    send_history(15, 0, 8'd2);
    write_reg(REG_WINDOW, 64'h7ff);
    send_history(40, 0, 8'd2);
    write_reg(REG_WINDOW, 64'd12);
    send_history(20, 0, 8'd2);
  endtask

  task automatic test_spacing_and_floor();
    write_reg(REG_SPACING, 64'd0);
    send_history(14, 0, 8'd2);
    write_reg(REG_SPACING, 64'h1ffff);
    write_reg(REG_MIN_EARLY, '1);
    send_history(12, 0, 8'd1);
    write_reg(REG_TESTNET, 64'd1);
    write_reg(REG_MIN_NORMAL, '1);
    write_reg(REG_MIN_EARLY, 64'd1);
    send_history(12, 0, 8'd5);
    write_reg(REG_TESTNET, 64'd0);
    write_reg(REG_MIN_NORMAL, 64'd1);
    write_reg(REG_SPACING, 64'd1);
    send_history(13, 0, 8'd5);
  endtask

  task automatic test_window_change();
    write_reg(REG_SPACING, 64'd120);
    write_reg(REG_WINDOW, 64'd60);
    new_chain();
    send_history(20, 0, 8'd0);
    for (int i = 0; i < 14; i++) begin
      if (i == 7) write_reg(REG_WINDOW, 64'd12);
      chain_time = chain_time + 64'd100;
      chain_work = chain_work + 128'd5000;
      send_item(chain_time, chain_work, 8'd2, i == 13);
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 400;
    new_chain();
    for (int k = 0; k < 4; k++) send_history(12, 0, 8'd2);
  endtask

  task automatic test_random_phase(int unsigned idle_pct, int unsigned st_pct,
                                   int n_items);
    logic [63:0] win_pick [7] = '{64'd0, 64'd12, 64'd13, 64'd20, 64'd60,
                                  64'd1024, 64'h7ff};
    int stop_at;
    wait_idle();
    send_idle_pct = idle_pct;
    stall_pct = st_pct;
    write_reg(REG_SPACING, $urandom_range(3, 0) == 0 ? {$urandom, $urandom} :
              64'($urandom_range(600, 1)));
    write_reg(REG_WINDOW, win_pick[$urandom_range(6, 0)]);
    write_reg(REG_MIN_EARLY, $urandom_range(1, 0) ? {$urandom, $urandom} :
              64'($urandom_range(1000, 1)));
    write_reg(REG_MIN_NORMAL, 64'($urandom_range(200000, 1)));
    write_reg(REG_TESTNET, 64'($urandom_range(1, 0)));
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      new_chain();
      case ($urandom_range(9, 0))
        0:       send_history($urandom_range(6, 1), 1, 8'($urandom));
        1:       send_history($urandom_range(10, 1), 0, 8'($urandom));
        2:       send_history($urandom_range((window_eff() + 3 > 40) ? 40 :
                                             window_eff() + 3, 11), 0, 8'($urandom));
        default: send_history($urandom_range(24, 11), 0, 8'($urandom_range(3, 0)));
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end else if (hold_left > 0) begin
      hold_left--;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99, 0) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (difficulty_q.size() == 0) begin
        $error("unexpected difficulty item %0h", difficulty);
        errors++;
      end else if (difficulty !== difficulty_q[0]) begin
        $error("difficulty expected %0h actual %0h", difficulty_q[0],
               difficulty);
        errors++;
        void'(difficulty_q.pop_front());
      end else begin
        void'(difficulty_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("difficulty_retarget_lwma3_core_test failed");
      $finish;
    end
  end

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    spacing_reg = 17'd120;
    window_reg = 11'd60;
    floor_early_reg = 64'd1;
    floor_normal_reg = 64'd100000;
    testnet_reg = 1'b0;
    clear_history();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_histories();
    test_field_extremes();
    test_window_limits();
    test_spacing_and_floor();
    test_window_change();
    test_backpressure();
    test_random_phase(0, 0, 110);
    test_random_phase(83, 0, 110);
    test_random_phase(0, 83, 110);
    test_random_phase(21, 21, 120);

    wait_idle();
    $display("sent %0d history items, checked %0d difficulty results", items_sent,
             results_seen);
    $display("covered short and capped windows, wraps, floors and stalls");
    if (errors == 0 && difficulty_q.size() == 0) begin
      $display("difficulty_retarget_lwma3_core_test passed");
    end else begin
      $display("difficulty_retarget_lwma3_core_test failed");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/lwma3_pkg.sv
sv/lwma3_datapath.sv
sv/lwma3_ctrl.sv
sv/difficulty_retarget_lwma3_core.sv
dv/difficulty_retarget_lwma3_core_test.sv
